@@ rtl/rom_bus_address_translator_defines.svh @@
// Assertion helpers for the ROM bus address translator.
// Each macro expects clk and rst_n in scope.
`ifndef ROM_BUS_ADDRESS_TRANSLATOR_DEFINES_SVH
`define ROM_BUS_ADDRESS_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define RBAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbat: same-cycle check failed");

// next-cycle implication
`define RBAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbat: next-cycle check failed");

`endif

@@ rtl/rbat_pkg.sv @@
package rbat_pkg;

  // memory map codes
  localparam logic [2:0] MAP_LO       = 3'd0;
  localparam logic [2:0] MAP_HI       = 3'd1;
  localparam logic [2:0] MAP_EXLO     = 3'd2;
  localparam logic [2:0] MAP_EXHI     = 3'd3;
  localparam logic [2:0] MAP_SLOT     = 3'd4;
  localparam logic [2:0] MAP_UNIMPL   = 3'd5;
  localparam logic [2:0] MAP_UNKNOWN  = 3'd6;
  localparam logic [2:0] MAP_RESERVED = 3'd7;  // no map behind this code

  // configuration register indexes
  localparam logic [2:0] REG_MAP_MODE  = 3'd0;
  localparam logic [2:0] REG_ROM_SIZE  = 3'd1;
  localparam logic [2:0] REG_SLOT_HIGH = 3'd2;
  localparam logic [2:0] REG_SLOT_B0   = 3'd3;
  localparam logic [2:0] REG_SLOT_B1   = 3'd4;
  localparam logic [2:0] REG_SLOT_B2   = 3'd5;
  localparam logic [2:0] REG_SLOT_B3   = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned ADDR_IN_W  = 32;
  localparam int unsigned ADDR_OUT_W = 24;

  // map limits
  localparam logic [21:0] EXHI_BUS_LIMIT = 22'h3e0000;
  localparam logic [23:0] EXLO_OFF_LIMIT = 24'h7f0000;
  localparam logic [23:0] EXHI_OFF_LIMIT = 24'h7e0000;

  // low-style bus bank for each coprocessor slot, slot 0 in the low byte
  localparam logic [3:0][7:0] SLOT_LO_BANK = {8'ha0, 8'h80, 8'h20, 8'h00};

  localparam logic [3:0][7:0] SLOT_BASE_RST = {8'h30, 8'h20, 8'h10, 8'h00};

  typedef struct packed {
    logic [2:0]       map_mode;
    logic [23:0]      rom_size;
    logic             slot_high_map;
    logic [3:0][7:0]  slot_base;
  } cfg_t;

  typedef struct packed {
    logic [23:0] addr;
    logic        ok;
  } xlate_res_t;

endpackage

@@ rtl/rbat_cfg_regs.sv @@
module rbat_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rbat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbat_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rbat_pkg::cfg_t                      cfg
);

  rbat_pkg::cfg_t cfg_r;
  rbat_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rbat_pkg::REG_MAP_MODE:  cfg_nxt.map_mode      = cfg_data[2:0];
        rbat_pkg::REG_ROM_SIZE:  cfg_nxt.rom_size      = cfg_data[23:0];
        rbat_pkg::REG_SLOT_HIGH: cfg_nxt.slot_high_map = cfg_data[0];
        rbat_pkg::REG_SLOT_B0:   cfg_nxt.slot_base[0]  = cfg_data[7:0];
        rbat_pkg::REG_SLOT_B1:   cfg_nxt.slot_base[1]  = cfg_data[7:0];
        rbat_pkg::REG_SLOT_B2:   cfg_nxt.slot_base[2]  = cfg_data[7:0];
        rbat_pkg::REG_SLOT_B3:   cfg_nxt.slot_base[3]  = cfg_data[7:0];
        default: ;  // no register there
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_mode      <= rbat_pkg::MAP_UNKNOWN;
      cfg_r.rom_size      <= '0;
      cfg_r.slot_high_map <= 1'b0;
      cfg_r.slot_base     <= rbat_pkg::SLOT_BASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/rbat_xlate.sv @@
module rbat_xlate (
  input  rbat_pkg::cfg_t                     cfg,
  input  logic                               cmd,
  input  logic [rbat_pkg::ADDR_IN_W-1:0]     addr_in,
  output rbat_pkg::xlate_res_t               res
);

  logic        hi_zero;
  logic [7:0]  bank;
  logic [7:0]  base_hi;
  logic [7:0]  base_lo;

  // bus -> offset
  logic        fwd_map_ok;
  logic [24:0] fwd_off;
  logic        fwd_ok;

  // offset -> bus
  logic [3:0]  slot_hit;
  logic [1:0]  sel;
  logic [7:0]  sel_base;
  logic [7:0]  hi_sum;
  logic [7:0]  lo_sum;
  logic        in_rom;
  logic        rev_map_ok;
  logic [23:0] rev_addr;
  logic        rev_ok;

  assign hi_zero = (addr_in[31:24] == 8'h00);
  assign bank    = addr_in[23:16];
  assign base_hi = cfg.slot_base[bank[5:4]];
  assign base_lo = cfg.slot_base[{bank[7], bank[5]}];

  always_comb begin
    fwd_map_ok = 1'b0;
    fwd_off    = '0;
    case (cfg.map_mode)
      rbat_pkg::MAP_LO: begin
        fwd_map_ok = hi_zero && addr_in[15];
        fwd_off    = {3'b000, addr_in[22:16], addr_in[14:0]};
      end
      rbat_pkg::MAP_HI: begin
        fwd_map_ok = hi_zero;
        fwd_off    = {3'b000, addr_in[21:0]};
      end
      rbat_pkg::MAP_EXLO: begin
        // lower half of the bus goes to the upper 4 MB of the image
        fwd_map_ok = hi_zero && addr_in[15];
        fwd_off    = {2'b00, ~addr_in[23], addr_in[22:16], addr_in[14:0]};
      end
      rbat_pkg::MAP_EXHI: begin
        fwd_map_ok = hi_zero && addr_in[22] &&
                     (addr_in[23] || (addr_in[21:0] < rbat_pkg::EXHI_BUS_LIMIT));
        fwd_off    = {2'b00, ~addr_in[23], addr_in[21:0]};
      end
      rbat_pkg::MAP_SLOT: begin
        // only the low 24 bits take part; banks 40-7f are holes
        if (bank[7:6] == 2'b11) begin
          fwd_map_ok = 1'b1;
          fwd_off    = {({1'b0, base_hi} + {5'b0, bank[3:0]}), addr_in[15:0]};
        end else begin
          fwd_map_ok = (bank[7:6] != 2'b01) && addr_in[15];
          fwd_off    = {1'b0, base_lo, 16'h0000} +
                       {5'b0, bank[4:0], addr_in[14:0]};
        end
      end
      default: begin
        fwd_map_ok = 1'b0;
        fwd_off    = '0;
      end
    endcase
  end

  assign fwd_ok = fwd_map_ok && (fwd_off < {1'b0, cfg.rom_size});

  // slot lookup, lowest slot wins
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      slot_hit[i] = ({1'b0, cfg.slot_base[i]} <= {1'b0, bank}) &&
                    (({1'b0, cfg.slot_base[i]} + 9'd16) > {1'b0, bank});
    end
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (slot_hit[i]) sel = 2'(i);
    end
  end

  assign sel_base = cfg.slot_base[sel];
  assign hi_sum   = {1'b0, sel_base[6:0]} + {4'b0, bank[3:0]};
  // bit 16 of the offset carries into the bank in low style
  assign lo_sum   = rbat_pkg::SLOT_LO_BANK[sel] + {4'b0, bank[3:0]} +
                    {7'b0, addr_in[16]};
  assign in_rom   = hi_zero && (addr_in[23:0] < cfg.rom_size);

  always_comb begin
    rev_map_ok = 1'b0;
    rev_addr   = '0;
    case (cfg.map_mode)
      rbat_pkg::MAP_LO: begin
        rev_map_ok = (addr_in[23:22] == 2'b00);
        rev_addr   = {1'b1, addr_in[21:15], 1'b1, addr_in[14:0]};
      end
      rbat_pkg::MAP_HI: begin
        rev_map_ok = (addr_in[23:22] == 2'b00);
        rev_addr   = {2'b11, addr_in[21:0]};
      end
      rbat_pkg::MAP_EXLO: begin
        rev_map_ok = (addr_in[23:0] < rbat_pkg::EXLO_OFF_LIMIT);
        rev_addr   = {~addr_in[22], addr_in[21:15], 1'b1, addr_in[14:0]};
      end
      rbat_pkg::MAP_EXHI: begin
        rev_map_ok = (addr_in[23:0] < rbat_pkg::EXHI_OFF_LIMIT);
        rev_addr   = {~addr_in[22], 1'b1, addr_in[21:0]};
      end
      rbat_pkg::MAP_SLOT: begin
        rev_map_ok = !addr_in[23] && (slot_hit != 4'b0000);
        if (cfg.slot_high_map) begin
          rev_addr = {(hi_sum | 8'hc0), addr_in[15:0]};
        end else begin
          rev_addr = {lo_sum, 1'b1, addr_in[14:0]};
        end
      end
      default: begin
        rev_map_ok = 1'b0;
        rev_addr   = '0;
      end
    endcase
  end

  assign rev_ok = in_rom && rev_map_ok;

  always_comb begin
    res.ok   = cmd ? rev_ok : fwd_ok;
    res.addr = '0;
    if (res.ok) begin
      res.addr = cmd ? rev_addr : fwd_off[23:0];
    end
  end

endmodule

@@ rtl/rom_bus_address_translator.sv @@
// Stages: input register, then result register; one item per cycle while the
// output is not stalled, and up to two items are held while it is stalled.
// Reset (rst_n low, synchronous): pipeline emptied, map = unknown, ROM size 0,
// slot bases 0x00/0x10/0x20/0x30, low-style slot map.
// Configuration must be written only with the pipeline empty.
`include "rom_bus_address_translator_defines.svh"

module rom_bus_address_translator (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [rbat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbat_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rbat_pkg::ADDR_IN_W-1:0]      in_tdata,   // [31:0] address_in
  input  logic                                in_tuser,   // [0] cmd
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rbat_pkg::ADDR_OUT_W-1:0]     out_tdata,  // [23:0] address_out
  output logic                                out_tuser   // [0] valid_res
);

  rbat_pkg::cfg_t       cfg;
  rbat_pkg::xlate_res_t xres;

  // stage 1: input register
  logic                              s1_valid_r, s1_valid_nxt;
  logic                              s1_cmd_r;
  logic [rbat_pkg::ADDR_IN_W-1:0]    s1_addr_r;
  // stage 2: result register
  logic                              out_valid_r, out_valid_nxt;
  rbat_pkg::xlate_res_t              out_res_r;

  logic s1_adv;
  logic in_fire;

  rbat_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // all translation logic sits between the two registers
  rbat_xlate u_xlate (
    .cfg     (cfg),
    .cmd     (s1_cmd_r),
    .addr_in (s1_addr_r),
    .res     (xres)
  );

  // stage 1 moves on whenever the result register is empty or being drained
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) s1_valid_nxt = in_tvalid;
    if (s1_adv) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_addr_r <= in_tdata;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= xres;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.addr;
  assign out_tuser  = out_res_r.ok;

  // a failed translation never shows an address
  `RBAT_ASSERT_IMP(a_fail_zero, out_tvalid && !out_tuser, out_tdata == '0)
  // input back-pressure only when both stages are full and the output stalls
  `RBAT_ASSERT_IMP(a_ready_cause, !in_tready, s1_valid_r && out_tvalid && !out_tready)
  // an accepted item is held in stage 1 on the next cycle
  `RBAT_ASSERT_NXT(a_accept_held, in_tvalid && in_tready, s1_valid_r)
  // maps without a translation always give failed results
  `RBAT_ASSERT_IMP(a_dead_maps,
    out_tvalid && (cfg.map_mode == rbat_pkg::MAP_UNIMPL ||
                   cfg.map_mode == rbat_pkg::MAP_UNKNOWN ||
                   cfg.map_mode == rbat_pkg::MAP_RESERVED),
    !out_tuser)

endmodule
